[hdl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg: shared types and helpers of the complex arithmetic unit
// Word sizes, command and status codes, the item record that travels
// down the cell chain, and the signed-magnitude helpers.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SHIFT_BITS = WORD_BITS - FRAC_BITS;
    localparam int ROOT_REM_BITS = WORD_BITS + 4;
    localparam int NUM_CELLS = WORD_BITS;

    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_SUB   = 3'd1;
    localparam logic [2:0] CMD_MUL   = 3'd2;
    localparam logic [2:0] CMD_SCALE = 3'd3;
    localparam logic [2:0] CMD_DIV   = 3'd4;
    localparam logic [2:0] CMD_EQ    = 3'd5;
    localparam logic [2:0] CMD_NE    = 3'd6;
    localparam logic [2:0] CMD_MAG   = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic                 neg;
        logic [PROD_BITS-1:0] mag;
    } sm_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] val;
        logic                 sat;
    } sw_t;

    // One item in flight through the cell chain.
    typedef struct packed {
        logic [2:0]               cmd;
        logic [WORD_BITS-1:0]     res_re;
        logic [WORD_BITS-1:0]     res_im;
        logic                     cmp;
        logic [1:0]               status;
        logic [PROD_BITS-1:0]     den;
        logic                     re_neg;
        logic                     im_neg;
        logic                     re_ovf;
        logic                     im_ovf;
        logic [PROD_BITS-1:0]     re_rem;
        logic [PROD_BITS-1:0]     im_rem;
        logic [WORD_BITS-1:0]     re_w;
        logic [WORD_BITS-1:0]     im_w;
        logic [PROD_BITS-1:0]     sq_v;
        logic [ROOT_REM_BITS-1:0] sq_rem;
        logic [WORD_BITS-1:0]     sq_root;
    } cell_t;

    function automatic sm_t neg_sm(input sm_t x);
        sm_t r;
        r.mag = x.mag;
        r.neg = !x.neg && (x.mag != '0);
        return r;
    endfunction

    function automatic sm_t add_sm(input sm_t x, input sm_t y);
        sm_t r;
        if (x.neg == y.neg) begin
            r.mag = x.mag + y.mag;
            r.neg = x.neg;
        end else if (x.mag >= y.mag) begin
            r.mag = x.mag - y.mag;
            r.neg = x.neg;
        end else begin
            r.mag = y.mag - x.mag;
            r.neg = y.neg;
        end
        if (r.mag == '0) begin
            r.neg = 1'b0;
        end
        return r;
    endfunction

    // Clamp a signed magnitude to the word range.
    function automatic sw_t sat_word(input logic neg, input logic [PROD_BITS-1:0] mag);
        sw_t r;
        logic [PROD_BITS-1:0] lim;
        lim = PROD_BITS'(1) << (WORD_BITS - 1);
        if (neg) begin
            r.sat = mag > lim;
            r.val = r.sat ? WORD_BITS'(lim) : WORD_BITS'(~mag + 1'b1);
        end else begin
            r.sat = mag > (lim - 1'b1);
            r.val = r.sat ? WORD_BITS'(lim - 1'b1) : WORD_BITS'(mag);
        end
        return r;
    endfunction

endpackage

[hdl/complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit: complex-number ALU on signed Q16.16 operands
// Add, subtract, multiply, scale, divide, compare and magnitude, fully
// pipelined through a chain of restoring division and square root cells.
// ----------------------------------------------------------------------------
// Every command takes the same path from acceptance to a valid result:
// 4 setup stages, 32 chain cells and 1 output register.
// Throughput: one item per cycle when not stalled; the 32-cell chain takes
// one quotient and one root bit per cell, so every stage holds its own item.
// Reset clears only the valid bits; the block is empty right after reset.
module complex_arith_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    cmd,
    input  logic [cau_pkg::WORD_BITS-1:0] a_re,
    input  logic [cau_pkg::WORD_BITS-1:0] a_im,
    input  logic [cau_pkg::WORD_BITS-1:0] b_re,
    input  logic [cau_pkg::WORD_BITS-1:0] b_im,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cau_pkg::WORD_BITS-1:0] res_re,
    output logic [cau_pkg::WORD_BITS-1:0] res_im,
    output logic                          cmp_true,
    output logic [1:0]                    status
);
    import cau_pkg::*;

    localparam int W = WORD_BITS;
    localparam int P = PROD_BITS;

    // The whole pipeline moves as one: it advances whenever the output
    // register is empty or its item is being taken this cycle.
    logic adv;

    logic                 chain_valid [NUM_CELLS+1];
    cell_t                chain_item  [NUM_CELLS+1];

    logic                 out_valid_reg;
    logic [W-1:0]         res_re_reg, res_re_next;
    logic [W-1:0]         res_im_reg, res_im_next;
    logic                 cmp_reg, cmp_next;
    logic [1:0]           status_reg, status_next;

    assign adv = !out_valid_reg || out_ready;
    assign in_ready = adv;

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .out_valid (chain_valid[0]),
        .out_item  (chain_item[0])
    );

    // Each cell retires one bit of both quotient parts and one root bit.
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        cau_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    // Final clamp of the quotient and root; the other commands finished
    // before the chain and only ride along.
    always_comb
    begin
        cell_t it;
        sw_t   qr, qi, rt;
        it = chain_item[NUM_CELLS];
        qr = sat_word(it.re_neg, P'(it.re_w));
        qi = sat_word(it.im_neg, P'(it.im_w));
        rt = sat_word(1'b0, P'(it.sq_root));
        res_re_next = it.res_re;
        res_im_next = it.res_im;
        cmp_next = it.cmp;
        status_next = it.status;
        case (it.cmd)
            CMD_DIV: begin
                if (it.status != ST_DIV0) begin
                    res_re_next = it.re_ovf ? (it.re_neg ? {1'b1, {(W-1){1'b0}}}
                                                         : {1'b0, {(W-1){1'b1}}}) : qr.val;
                    res_im_next = it.im_ovf ? (it.im_neg ? {1'b1, {(W-1){1'b0}}}
                                                         : {1'b0, {(W-1){1'b1}}}) : qi.val;
                    status_next = (it.re_ovf || it.im_ovf || qr.sat || qi.sat) ? ST_SAT : ST_OK;
                end
            end
            CMD_MAG: begin
                res_re_next = rt.val;
                res_im_next = '0;
                status_next = rt.sat ? ST_SAT : ST_OK;
            end
            default: begin
                status_next = it.status;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= chain_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            cmp_reg <= cmp_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_re = res_re_reg;
    assign res_im = res_im_reg;
    assign cmp_true = cmp_reg;
    assign status = status_reg;

`ifndef ASSERT_OFF
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output register");
    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_DIV0) |-> (res_re == '0 && res_im == '0 && !cmp_true))
        else $error("divide by zero item carries a nonzero result");
    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cmp_true) |-> (status == ST_OK && res_re == '0 && res_im == '0))
        else $error("compare item carries a result or a status");
    a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 2'd3))
        else $error("unused status code on the output");
`endif

endmodule

[hdl/cau_front.sv]
// ----------------------------------------------------------------------------
// cau_front: operand staging, products and item setup
// Four register stages: magnitudes, products, signed sums, and the
// record that enters the cell chain.
// ----------------------------------------------------------------------------
module cau_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [2:0]                    cmd,
    input  logic [cau_pkg::WORD_BITS-1:0] a_re,
    input  logic [cau_pkg::WORD_BITS-1:0] a_im,
    input  logic [cau_pkg::WORD_BITS-1:0] b_re,
    input  logic [cau_pkg::WORD_BITS-1:0] b_im,
    output logic                          out_valid,
    output cau_pkg::cell_t                out_item
);
    import cau_pkg::*;

    localparam int W = WORD_BITS;
    localparam int P = PROD_BITS;

    // Stage A
    logic [2:0]   a_cmd_reg;
    logic [W-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic [W-1:0] arm_reg, aim_reg, brm_reg, bim_reg;
    logic         ars_reg, ais_reg, brs_reg, bis_reg;
    logic [3:0]   valid_reg;

    // Stage B
    logic [2:0]   b_cmd_reg;
    logic [W:0]   sum_re_reg, sum_im_reg;
    logic         b_eq_reg;
    sm_t          p_arbr_reg, p_aibi_reg, p_arbi_reg, p_aibr_reg;
    logic [P-1:0] p_arar_reg, p_aiai_reg, p_brbr_reg, p_bibi_reg;

    // Stage C
    logic [2:0]   c_cmd_reg;
    logic [W:0]   c_sum_re_reg, c_sum_im_reg;
    logic         c_eq_reg;
    sm_t          mul_re_reg, mul_im_reg, div_re_reg, div_im_reg, sc_re_reg, sc_im_reg;
    logic [P-1:0] den_reg, sq_reg;

    cell_t        item_reg, item_next;

    function automatic logic [W-1:0] abs_w(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic sw_t sat_sum(input logic [W:0] s);
        sw_t r;
        r.sat = s[W] != s[W-1];
        if (r.sat) begin
            r.val = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            r.val = s[W-1:0];
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            a_cmd_reg <= cmd;
            ar_reg <= a_re;
            ai_reg <= a_im;
            br_reg <= b_re;
            bi_reg <= b_im;
            arm_reg <= abs_w(a_re);
            aim_reg <= abs_w(a_im);
            brm_reg <= abs_w(b_re);
            bim_reg <= abs_w(b_im);
            ars_reg <= a_re[W-1];
            ais_reg <= a_im[W-1];
            brs_reg <= b_re[W-1];
            bis_reg <= b_im[W-1];

            b_cmd_reg <= a_cmd_reg;
            if (a_cmd_reg == CMD_SUB) begin
                sum_re_reg <= {ar_reg[W-1], ar_reg} - {br_reg[W-1], br_reg};
                sum_im_reg <= {ai_reg[W-1], ai_reg} - {bi_reg[W-1], bi_reg};
            end else begin
                sum_re_reg <= {ar_reg[W-1], ar_reg} + {br_reg[W-1], br_reg};
                sum_im_reg <= {ai_reg[W-1], ai_reg} + {bi_reg[W-1], bi_reg};
            end
            b_eq_reg <= (ar_reg == br_reg) && (ai_reg == bi_reg);
            p_arbr_reg.mag <= P'(arm_reg) * P'(brm_reg);
            p_aibi_reg.mag <= P'(aim_reg) * P'(bim_reg);
            p_arbi_reg.mag <= P'(arm_reg) * P'(bim_reg);
            p_aibr_reg.mag <= P'(aim_reg) * P'(brm_reg);
            p_arbr_reg.neg <= (ars_reg ^ brs_reg) && (arm_reg != '0) && (brm_reg != '0);
            p_aibi_reg.neg <= (ais_reg ^ bis_reg) && (aim_reg != '0) && (bim_reg != '0);
            p_arbi_reg.neg <= (ars_reg ^ bis_reg) && (arm_reg != '0) && (bim_reg != '0);
            p_aibr_reg.neg <= (ais_reg ^ brs_reg) && (aim_reg != '0) && (brm_reg != '0);
            p_arar_reg <= P'(arm_reg) * P'(arm_reg);
            p_aiai_reg <= P'(aim_reg) * P'(aim_reg);
            p_brbr_reg <= P'(brm_reg) * P'(brm_reg);
            p_bibi_reg <= P'(bim_reg) * P'(bim_reg);

            c_cmd_reg <= b_cmd_reg;
            c_sum_re_reg <= sum_re_reg;
            c_sum_im_reg <= sum_im_reg;
            c_eq_reg <= b_eq_reg;
            mul_re_reg <= add_sm(p_arbr_reg, neg_sm(p_aibi_reg));
            mul_im_reg <= add_sm(p_arbi_reg, p_aibr_reg);
            div_re_reg <= add_sm(p_arbr_reg, p_aibi_reg);
            div_im_reg <= add_sm(p_aibr_reg, neg_sm(p_arbi_reg));
            sc_re_reg <= p_arbr_reg;
            sc_im_reg <= p_aibr_reg;
            den_reg <= p_brbr_reg + p_bibi_reg;
            sq_reg <= p_arar_reg + p_aiai_reg;

            item_reg <= item_next;
        end
    end

    always_comb
    begin
        sw_t sr;
        sw_t si;
        sr = sat_sum(c_sum_re_reg);
        si = sat_sum(c_sum_im_reg);
        item_next = '0;
        item_next.cmd = c_cmd_reg;
        item_next.den = den_reg;
        item_next.re_neg = div_re_reg.neg;
        item_next.im_neg = div_im_reg.neg;
        item_next.re_ovf = (div_re_reg.mag >> SHIFT_BITS) >= den_reg;
        item_next.im_ovf = (div_im_reg.mag >> SHIFT_BITS) >= den_reg;
        item_next.re_rem = div_re_reg.mag >> SHIFT_BITS;
        item_next.im_rem = div_im_reg.mag >> SHIFT_BITS;
        item_next.re_w = W'(div_re_reg.mag << FRAC_BITS);
        item_next.im_w = W'(div_im_reg.mag << FRAC_BITS);
        item_next.sq_v = sq_reg;
        case (c_cmd_reg)
            CMD_ADD, CMD_SUB: begin
                item_next.res_re = sr.val;
                item_next.res_im = si.val;
                item_next.status = (sr.sat || si.sat) ? ST_SAT : ST_OK;
            end
            CMD_MUL: begin
                sr = sat_word(mul_re_reg.neg, mul_re_reg.mag >> FRAC_BITS);
                si = sat_word(mul_im_reg.neg, mul_im_reg.mag >> FRAC_BITS);
                item_next.res_re = sr.val;
                item_next.res_im = si.val;
                item_next.status = (sr.sat || si.sat) ? ST_SAT : ST_OK;
            end
            CMD_SCALE: begin
                sr = sat_word(sc_re_reg.neg, sc_re_reg.mag >> FRAC_BITS);
                si = sat_word(sc_im_reg.neg, sc_im_reg.mag >> FRAC_BITS);
                item_next.res_re = sr.val;
                item_next.res_im = si.val;
                item_next.status = (sr.sat || si.sat) ? ST_SAT : ST_OK;
            end
            CMD_DIV: begin
                item_next.status = (den_reg == '0) ? ST_DIV0 : ST_OK;
            end
            CMD_EQ: begin
                item_next.cmp = c_eq_reg;
            end
            CMD_NE: begin
                item_next.cmp = !c_eq_reg;
            end
            default: begin
                item_next.status = ST_OK;
            end
        endcase
    end

    assign out_valid = valid_reg[3];
    assign out_item = item_reg;

endmodule

[hdl/cau_cell.sv]
// ----------------------------------------------------------------------------
// cau_cell: one step of the division and square root chain
// Takes one quotient bit for each part of a quotient and one root bit,
// then hands the item to the next cell.
// ----------------------------------------------------------------------------
module cau_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  cau_pkg::cell_t in_item,
    output logic           out_valid,
    output cau_pkg::cell_t out_item
);
    import cau_pkg::*;

    localparam int W = WORD_BITS;
    localparam int P = PROD_BITS;
    localparam int R = ROOT_REM_BITS;

    logic  valid_reg;
    cell_t item_reg, item_next;

    always_comb
    begin
        logic [P-1:0] r_re, r_im;
        logic [R-1:0] r_sq, trial;
        logic         ge_re, ge_im, ge_sq;
        item_next = in_item;

        r_re = {in_item.re_rem[P-2:0], in_item.re_w[W-1]};
        ge_re = r_re >= in_item.den;
        item_next.re_rem = ge_re ? (r_re - in_item.den) : r_re;
        item_next.re_w = {in_item.re_w[W-2:0], ge_re};

        r_im = {in_item.im_rem[P-2:0], in_item.im_w[W-1]};
        ge_im = r_im >= in_item.den;
        item_next.im_rem = ge_im ? (r_im - in_item.den) : r_im;
        item_next.im_w = {in_item.im_w[W-2:0], ge_im};

        r_sq = {in_item.sq_rem[R-3:0], in_item.sq_v[P-1:P-2]};
        trial = R'({in_item.sq_root, 2'b01});
        ge_sq = r_sq >= trial;
        item_next.sq_rem = ge_sq ? (r_sq - trial) : r_sq;
        item_next.sq_root = {in_item.sq_root[W-2:0], ge_sq};
        item_next.sq_v = in_item.sq_v << 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item = item_reg;

endmodule

[test/complex_arith_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_arith_unit_tb: self-checking bench of the complex arithmetic unit
// Drives directed corner items and then random items through the valid and
// ready handshake, idles and stalls both sides at random, and compares each
// result with a Q16.16 predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module complex_arith_unit_tb;

    import cau_pkg::*;

    localparam int NUM_RANDOM = 1800;
    localparam int DRAIN_CYCLES = 60;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        cmp;
        logic [1:0]  st;
    } alu_result_t;

    // The scoreboard predicts every accepted item and holds the predictions
    // in order until the matching result leaves the block.
    class alu_scoreboard;
        alu_result_t pending_q[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        static function wide_t widen(logic [31:0] w);
            return {{96{w[31]}}, w};
        endfunction

        // Clamp an exact value to the word range and note any clamping.
        static function logic [31:0] clamp(wide_t v, inout bit sat);
            wide_t hi;
            wide_t lo;
            hi = 128'sh7fffffff;
            lo = -128'sh80000000;
            if (v > hi) begin
                sat = 1'b1;
                return 32'h7fffffff;
            end
            if (v < lo) begin
                sat = 1'b1;
                return 32'h80000000;
            end
            return v[31:0];
        endfunction

        // Drop the fraction bits of a product, rounding toward zero.
        static function wide_t drop_frac(wide_t v);
            if (v < 0)
                return -((-v) >>> FRAC_BITS);
            return v >>> FRAC_BITS;
        endfunction

        // Quotient of num * 2^FRAC_BITS over den, truncated toward zero.
        static function wide_t frac_quot(wide_t num, logic [127:0] den);
            logic [127:0] mag;
            logic [127:0] q;
            mag = (num < 0) ? 128'(-num) : 128'(num);
            q = (mag << FRAC_BITS) / den;
            if (num < 0)
                return -$signed(q);
            return $signed(q);
        endfunction

        static function logic [127:0] int_sqrt(logic [127:0] v);
            logic [127:0] root;
            logic [127:0] bitv;
            root = '0;
            bitv = 128'd1 << 126;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        function void note_item(logic [2:0] op, logic [31:0] ar, logic [31:0] ai,
                                logic [31:0] br, logic [31:0] bi);
            alu_result_t r;
            wide_t xr, xi, yr, yi;
            logic [127:0] den;
            bit sat;
            xr = widen(ar);
            xi = widen(ai);
            yr = widen(br);
            yi = widen(bi);
            sat = 1'b0;
            r.re = '0;
            r.im = '0;
            r.cmp = 1'b0;
            r.st = ST_OK;
            case (op)
                CMD_ADD:
                begin
                    r.re = clamp(xr + yr, sat);
                    r.im = clamp(xi + yi, sat);
                end
                CMD_SUB:
                begin
                    r.re = clamp(xr - yr, sat);
                    r.im = clamp(xi - yi, sat);
                end
                CMD_MUL:
                begin
                    r.re = clamp(drop_frac(xr * yr - xi * yi), sat);
                    r.im = clamp(drop_frac(xr * yi + xi * yr), sat);
                end
                CMD_SCALE:
                begin
                    r.re = clamp(drop_frac(xr * yr), sat);
                    r.im = clamp(drop_frac(xi * yr), sat);
                end
                CMD_DIV:
                begin
                    den = 128'(yr * yr + yi * yi);
                    if (den == 0) begin
                        r.st = ST_DIV0;
                    end else begin
                        r.re = clamp(frac_quot(xr * yr + xi * yi, den), sat);
                        r.im = clamp(frac_quot(xi * yr - xr * yi, den), sat);
                    end
                end
                CMD_EQ:
                    r.cmp = (ar == br) && (ai == bi);
                CMD_NE:
                    r.cmp = !((ar == br) && (ai == bi));
                default:
                    r.re = clamp($signed(int_sqrt(128'(xr * xr + xi * xi))), sat);
            endcase
            if (sat && r.st == ST_OK)
                r.st = ST_SAT;
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [31:0] re, logic [31:0] im, logic cmp,
                                   logic [1:0] st);
            alu_result_t e;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: re=%h im=%h cmp=%b st=%0d",
                             re, im, cmp, st);
                return;
            end
            e = pending_q.pop_front();
            if (re !== e.re || im !== e.im || cmp !== e.cmp || st !== e.st) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected re=%h im=%h cmp=%b st=%0d,",
                              " got re=%h im=%h cmp=%b st=%0d"},
                             e.re, e.im, e.cmp, e.st, re, im, cmp, st);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  cmd;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [31:0] b_re;
    logic [31:0] b_im;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic        cmp_true;
    logic [1:0]  status;

    alu_scoreboard sb;
    bit            quiet;

    complex_arith_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_re    (res_re),
        .res_im    (res_im),
        .cmp_true  (cmp_true),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Both handshakes are observed at the clock edge, before any of the
    // nonblocking updates of that edge land.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_item(cmd, a_re, a_im, b_re, b_im);
        if (rst_n && out_valid && out_ready)
            sb.check_result(res_re, res_im, cmp_true, status);
    end

    // The receiver stalls in short random bursts until the last part of
    // the run, where it always takes results.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Holds the item on the inputs until the block accepts it.
    task automatic send_item(logic [2:0] op, logic [31:0] ar, logic [31:0] ai,
                             logic [31:0] br, logic [31:0] bi);
        in_valid <= 1'b1;
        cmd <= op;
        a_re <= ar;
        a_im <= ai;
        b_re <= br;
        b_im <= bi;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic idle_burst();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Operand values lean on the corners of Q16.16 as well as full random
    // words, and small values that keep products in range.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h00000000;
            3: return 32'h00010000;
            4: return 32'hffff0000;
            5, 6: return $urandom_range(0, 32'h001fffff) - 32'h00100000;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_directed();
        send_item(CMD_ADD, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff);
        send_item(CMD_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_item(CMD_ADD, 32'h00018000, 32'hfffe0000, 32'h00008000, 32'h00010000);
        send_item(CMD_SUB, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff);
        send_item(CMD_SUB, 32'h00030000, 32'h00010000, 32'h00010000, 32'h00030000);
        send_item(CMD_MUL, 32'h00020000, 32'h00030000, 32'h00040000, 32'hffff0000);
        send_item(CMD_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_item(CMD_MUL, 32'hffffffff, 32'h00000001, 32'h00000001, 32'h00000001);
        send_item(CMD_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_item(CMD_SCALE, 32'h00018000, 32'hfffe8000, 32'hfffe0000, 32'h12345678);
        send_item(CMD_SCALE, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h00000000);
        send_item(CMD_DIV, 32'h00010000, 32'h00020000, 32'h00000000, 32'h00000000);
        send_item(CMD_DIV, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000);
        send_item(CMD_DIV, 32'h00030000, 32'h00040000, 32'h00010000, 32'hffff0000);
        send_item(CMD_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h00000000);
        send_item(CMD_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_item(CMD_DIV, 32'hffffffff, 32'h00000001, 32'h7fffffff, 32'h80000000);
        send_item(CMD_EQ, 32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef0);
        send_item(CMD_EQ, 32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef1);
        send_item(CMD_NE, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_item(CMD_NE, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_item(CMD_MAG, 32'h00030000, 32'hfffc0000, 32'h00000000, 32'h00000000);
        send_item(CMD_MAG, 32'h80000000, 32'h80000000, 32'hffffffff, 32'hffffffff);
        send_item(CMD_MAG, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000);
        send_item(CMD_MAG, 32'h7fffffff, 32'h00000000, 32'h00000000, 32'h00000000);
    endtask

    task automatic run_random();
        logic [2:0]  op;
        logic [31:0] ar, ai, br, bi;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            // The final stretch runs with no idling on either side.
            if (n == NUM_RANDOM - 200)
                quiet = 1'b1;
            // Halfway through, let the block drain before going on.
            if (n == NUM_RANDOM / 2) begin
                in_valid <= 1'b0;
                while (sb.pending_q.size() != 0)
                    @(posedge clk);
            end
            op = 3'($urandom_range(0, 7));
            ar = pick_word();
            ai = pick_word();
            br = pick_word();
            bi = pick_word();
            // Compare commands need matching operands to be interesting.
            if ((op == CMD_EQ || op == CMD_NE) && $urandom_range(0, 1)) begin
                br = ar;
                bi = ai;
                if ($urandom_range(0, 2) == 0)
                    bi = bi ^ (32'h1 << $urandom_range(0, 31));
            end
            if (op == CMD_DIV && $urandom_range(0, 7) == 0) begin
                br = '0;
                bi = '0;
            end
            send_item(op, ar, ai, br, bi);
            idle_burst();
        end
    endtask

    initial
    begin
        sb = new();
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_ADD;
        a_re = '0;
        a_im = '0;
        b_re = '0;
        b_im = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
hdl/cau_pkg.sv
hdl/cau_front.sv
hdl/cau_cell.sv
hdl/complex_arith_unit.sv
test/complex_arith_unit_tb.sv
